>>> hdl/gab_pkg.sv
// Shared types and constants for the glyph alpha blit frame store.
package gab_pkg;

    typedef logic [1:0]         t_op;
    typedef logic signed [11:0] t_coord;
    typedef logic [7:0]         t_byte;
    typedef logic [31:0]        t_pixel;
    typedef logic [0:0]         t_reg_idx;

    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_BLEND = 2'd2;
    localparam t_op OP_NONE  = 2'd3;

    localparam t_reg_idx REG_ACTIVE_WIDTH  = 1'b0;
    localparam t_reg_idx REG_ACTIVE_HEIGHT = 1'b1;

    localparam t_byte AREA_RESET = 8'd128;
    localparam t_byte ALPHA_FULL = 8'hFF;
    localparam t_byte ALPHA_NONE = 8'h00;

endpackage

>>> hdl/gab_in_if.sv
// Input item channel: one read, write or glyph sample operation.
interface gab_in_if;
    import gab_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_coord pos_x;
    t_coord pos_y;
    t_pixel pixel_color;
    t_coord glyph_left;
    t_coord glyph_top;
    t_byte  glyph_width;
    t_byte  glyph_height;
    t_byte  sample_col;
    t_byte  sample_row;
    t_byte  alpha_value;

    modport source (
        output valid, operation, pos_x, pos_y, pixel_color, glyph_left, glyph_top,
               glyph_width, glyph_height, sample_col, sample_row, alpha_value,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, pixel_color, glyph_left, glyph_top,
               glyph_width, glyph_height, sample_col, sample_row, alpha_value,
        output ready
    );
endinterface

>>> hdl/gab_out_if.sv
// Result item channel: resulting pixel and area flag.
interface gab_out_if;
    import gab_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_value;
    logic   in_area;

    modport source (output valid, pixel_value, in_area, input ready);
    modport sink (input valid, pixel_value, in_area, output ready);
endinterface

>>> hdl/gab_cfg_if.sv
// Configuration write channel: register index and write data.
interface gab_cfg_if;
    import gab_pkg::*;

    logic     valid;
    logic     ready;
    t_reg_idx index;
    t_byte    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/glyph_alpha_blit_framebuffer.sv
// Top level: RGBA frame store with pixel read, pixel write and glyph alpha blend.
// The read-modify-write sequencer around the single frame store memory (one read,
// then one write for write and blend items) takes a new item only when idle, once the
// last result has been loaded into the output register.
// Reset is synchronous; afterwards a clearing pass zeroes the store, one word per
// cycle for all MAX_WIDTH*MAX_HEIGHT words (16384 by default), before items are taken.
module glyph_alpha_blit_framebuffer #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gab_in_if.sink    i_in,
    gab_out_if.source o_out,
    gab_cfg_if.sink   i_cfg
);
    import gab_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (AW > 17) ? AW : 17;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_MIX   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]    r_state;
    logic [AW-1:0] r_clr_cnt;
    t_byte         r_cfg_w;
    t_byte         r_cfg_h;

    t_op    r_op;
    t_coord r_px;
    t_coord r_py;
    t_pixel r_color;
    t_coord r_left;
    t_coord r_top;
    t_byte  r_gw;
    t_byte  r_gh;
    t_byte  r_col;
    t_byte  r_row;
    t_byte  r_alpha;

    t_byte         r_x;
    t_byte         r_y;
    logic          r_hit;
    logic [AW-1:0] r_idx;
    t_pixel        r_rdata;
    logic [15:0]   r_sum [4];
    t_pixel        r_value;

    logic   r_out_valid;
    t_pixel r_out_value;
    logic   r_out_hit;

    t_pixel r_mem [DEPTH];

    t_byte              eff_w;
    t_byte              eff_h;
    logic signed [13:0] tx;
    logic signed [13:0] ty;
    logic               in_glyph;
    logic               locate_ok;
    logic [PW-1:0]      idx_full;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_pixel             mem_wdata;
    t_pixel             blend_px;
    logic [16:0]        quo [4];
    t_byte              new_a;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_value = r_out_value;
    assign o_out.in_area     = r_out_hit;

    always_comb begin
        eff_w = ({5'd0, r_cfg_w} > 13'(MAX_WIDTH))  ? 8'(MAX_WIDTH)  : r_cfg_w;
        eff_h = ({5'd0, r_cfg_h} > 13'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : r_cfg_h;
    end

    always_comb begin
        if (r_op == OP_BLEND) begin
            tx = 14'(r_px) + 14'(r_left) + $signed({6'd0, r_col});
            ty = 14'(r_py) - 14'(r_top) + $signed({6'd0, r_gh}) + $signed({6'd0, r_row});
        end else begin
            tx = 14'(r_px);
            ty = 14'(r_py);
        end
        in_glyph  = (r_col < r_gw) && (r_row < r_gh);
        locate_ok = !tx[13] && !ty[13]
                    && (tx < $signed({6'd0, eff_w})) && (ty < $signed({6'd0, eff_h}));
    end

    assign idx_full = PW'(r_y) * PW'(eff_w) + PW'(r_x);

    // Divide by 255 via (s + 1 + (s >> 8)) >> 8, exact for sums up to 255*255.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            quo[i] = (17'(r_sum[i]) + 17'd1 + 17'(r_sum[i][15:8])) >> 8;
        end
        new_a = r_rdata[7:0] + quo[3][7:0];
        if (r_alpha == ALPHA_NONE) begin
            blend_px = r_rdata;
        end else if (r_alpha == ALPHA_FULL) begin
            blend_px = {r_color[31:8], ALPHA_FULL};
        end else begin
            blend_px = {quo[0][7:0], quo[1][7:0], quo[2][7:0], new_a};
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = blend_px;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = '0;
            end
            S_MIX: begin
                mem_we    = (r_op == OP_WRITE);
                mem_wdata = r_color;
            end
            S_DIV: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op    <= i_in.operation;
            r_px    <= i_in.pos_x;
            r_py    <= i_in.pos_y;
            r_color <= i_in.pixel_color;
            r_left  <= i_in.glyph_left;
            r_top   <= i_in.glyph_top;
            r_gw    <= i_in.glyph_width;
            r_gh    <= i_in.glyph_height;
            r_col   <= i_in.sample_col;
            r_row   <= i_in.sample_row;
            r_alpha <= i_in.alpha_value;
        end
        if (r_state == S_CALC) begin
            r_x <= tx[7:0];
            r_y <= ty[7:0];
        end
        if (r_state == S_MUL) begin
            r_idx <= idx_full[AW-1:0];
        end
        if (r_state == S_MIX) begin
            r_sum[0] <= 16'(r_color[31:24] * r_alpha) + 16'(r_rdata[31:24] * (ALPHA_FULL - r_alpha));
            r_sum[1] <= 16'(r_color[23:16] * r_alpha) + 16'(r_rdata[23:16] * (ALPHA_FULL - r_alpha));
            r_sum[2] <= 16'(r_color[15:8] * r_alpha) + 16'(r_rdata[15:8] * (ALPHA_FULL - r_alpha));
            r_sum[3] <= 16'((ALPHA_FULL - r_rdata[7:0]) * r_alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_cfg_w     <= AREA_RESET;
            r_cfg_h     <= AREA_RESET;
            r_hit       <= 1'b0;
            r_value     <= '0;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_out_hit   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_ACTIVE_WIDTH:  r_cfg_w <= i_cfg.data;
                    REG_ACTIVE_HEIGHT: r_cfg_h <= i_cfg.data;
                endcase
            end
            if (o_out.valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    unique case (r_op)
                        OP_READ, OP_WRITE: r_hit <= locate_ok;
                        OP_BLEND:          r_hit <= locate_ok && in_glyph;
                        default:           r_hit <= 1'b0;
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_hit) begin
                        r_state <= S_MIX;
                    end else begin
                        r_value <= '0;
                        r_state <= S_FIN;
                    end
                end
                S_MIX: begin
                    if (r_op == OP_BLEND) begin
                        r_state <= S_DIV;
                    end else begin
                        r_value <= (r_op == OP_WRITE) ? r_color : r_rdata;
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_value <= blend_px;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_value;
                        r_out_hit   <= r_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_value == '0))
        else $error("Clipped result carries a nonzero pixel.");

    a_write_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_CLEAR) |-> r_hit)
        else $error("Frame store written for an item outside the area.");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX && r_op == OP_READ) |-> !mem_we)
        else $error("Pixel read modified the frame store.");

    a_full_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_alpha == ALPHA_FULL) |-> (mem_wdata[7:0] == ALPHA_FULL))
        else $error("Full coverage blend did not give opaque alpha.");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("Result raised outside the final step.");

endmodule
